FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

FILE: hw/rtl/bpa_pkg.sv
// shared types and constants for the bitmap page allocator
package bpa_pkg;

    localparam int PAGES_DEFAULT = 4096;
    localparam int MAP_WORD_W    = 64;
    localparam int MAP_BIT_W     = $clog2(MAP_WORD_W);
    localparam int PAGE_W        = 12;
    localparam int CNT_W         = 13;

    localparam logic [CNT_W-1:0] TOP_PAGE_RESET = 13'd4096;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_CHECK = 2'd2,
        MODE_MARK  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_DOUBLE  = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        WALK_SCAN  = 2'd0,
        WALK_FILL  = 2'd1,
        WALK_CLEAR = 2'd2,
        WALK_PEEK  = 2'd3
    } walk_op_t;

    typedef enum logic [1:0] {
        WK_IDLE  = 2'd0,
        WK_READ  = 2'd1,
        WK_LOAD  = 2'd2,
        WK_SHIFT = 2'd3
    } walk_state_t;

    typedef enum logic [2:0] {
        CTL_IDLE  = 3'd0,
        CTL_SCAN1 = 3'd1,
        CTL_SCAN2 = 3'd2,
        CTL_FILL  = 3'd3,
        CTL_WALK  = 3'd4,
        CTL_OUT   = 3'd5
    } ctl_state_t;

    typedef struct packed {
        mode_t             mode;
        logic [PAGE_W-1:0] page_index;
        logic [CNT_W-1:0]  page_count;
    } in_item_t;

    typedef struct packed {
        logic [PAGE_W-1:0] result_page;
        status_t           status;
        logic              is_used;
    } out_item_t;

    typedef struct packed {
        logic     go;
        walk_op_t op;
        logic     check;
    } walk_cmd_t;

    typedef struct packed {
        logic done;
        logic found;
        logic dbl;
        logic bit_val;
    } walk_rsp_t;

endpackage

FILE: hw/rtl/bpa_map.sv
// used-map word memory with power-on sweep to all used
`include "assert_macros.svh"

module bpa_map #(
    parameter int PAGES = bpa_pkg::PAGES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [AWW-1:0]                rd_addr,
    output logic [bpa_pkg::MAP_WORD_W-1:0] rd_data,
    input  logic                          wr_en,
    input  logic [AWW-1:0]                wr_addr,
    input  logic [bpa_pkg::MAP_WORD_W-1:0] wr_data,
    output logic                          ready
);

    localparam int W     = bpa_pkg::MAP_WORD_W;
    localparam int DEPTH = (PAGES + W - 1) / W;
    localparam int AWW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]   mem [DEPTH];
    logic [W-1:0]   rd_data_reg;
    logic           init_busy_reg;
    logic           init_busy_next;
    logic [AWW-1:0] init_addr_reg;
    logic [AWW-1:0] init_addr_next;

    always_comb
    begin
        init_busy_next = init_busy_reg;
        init_addr_next = init_addr_reg;
        if (init_busy_reg)
        begin
            if (init_addr_reg == AWW'(DEPTH - 1))
            begin
                init_busy_next = 1'b0;
            end
            else
            begin
                init_addr_next = init_addr_reg + AWW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_busy_reg <= 1'b1;
            init_addr_reg <= '0;
        end
        else
        begin
            init_busy_reg <= init_busy_next;
            init_addr_reg <= init_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (init_busy_reg)
        begin
            mem[init_addr_reg] <= '1;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign ready   = !init_busy_reg;

    `ASSERT_NEVER(a_no_write_in_sweep, clk, rst_n, init_busy_reg && wr_en, "write during sweep")

endmodule

FILE: hw/rtl/bpa_walk.sv
// bit-serial walker: rotates one map word through a shift register a page per cycle, pausing to read and load each word
`include "assert_macros.svh"

module bpa_walk #(
    parameter int PAGES = bpa_pkg::PAGES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bpa_pkg::walk_cmd_t             cmd,
    input  logic [PW-1:0]                  lo,
    input  logic [PW-1:0]                  hi,
    input  logic [bpa_pkg::CNT_W-1:0]      cnt,
    output bpa_pkg::walk_rsp_t             rsp,
    output logic [PW-1:0]                  end_pos,
    output logic [AWW-1:0]                 rd_addr,
    input  logic [bpa_pkg::MAP_WORD_W-1:0] rd_data,
    output logic                           wr_en,
    output logic [AWW-1:0]                 wr_addr,
    output logic [bpa_pkg::MAP_WORD_W-1:0] wr_data
);

    localparam int W     = bpa_pkg::MAP_WORD_W;
    localparam int KW    = bpa_pkg::MAP_BIT_W;
    localparam int CW    = bpa_pkg::CNT_W;
    localparam int DEPTH = (PAGES + W - 1) / W;
    localparam int AWW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = AWW + KW + 1;
    localparam logic [KW-1:0] KMAX = KW'(W - 1);

    bpa_pkg::walk_state_t state_reg, state_next;
    bpa_pkg::walk_op_t    op_reg, op_next;
    logic                 check_reg, check_next;
    logic                 stop_reg, stop_next;
    bpa_pkg::walk_rsp_t   rsp_reg, rsp_next;
    logic [AWW-1:0]       w_reg, w_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [CW-1:0]        run_reg, run_next;
    logic [W-1:0]         shreg_reg, shreg_next;
    logic [PW-1:0]        end_reg, end_next;

    logic [PW-1:0] q;
    logic [PW-1:0] q_inc;
    logic [AWW:0]  w_inc;
    logic [PW-1:0] next_start;
    logic          last_word;
    logic          bit_cur;
    logic          active;
    logic          new_bit;
    logic [CW-1:0] run_inc;
    logic [W-1:0]  shift_val;

    always_comb
    begin
        q          = {1'b0, w_reg, k_reg};
        q_inc      = q + PW'(1);
        w_inc      = {1'b0, w_reg} + (AWW + 1)'(1);
        next_start = {w_inc, {KW{1'b0}}};
        last_word  = next_start >= hi;
        bit_cur    = shreg_reg[0];
        active     = !stop_reg && (q >= lo) && (q < hi);
        run_inc    = run_reg + CW'(1);
        new_bit    = bit_cur;
        if (active && op_reg == bpa_pkg::WALK_FILL)
        begin
            new_bit = 1'b1;
        end
        else if (active && op_reg == bpa_pkg::WALK_CLEAR)
        begin
            new_bit = 1'b0;
        end
        shift_val = {new_bit, shreg_reg[W-1:1]};
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        check_next = check_reg;
        stop_next  = stop_reg;
        rsp_next   = '0;
        w_next     = w_reg;
        k_next     = k_reg;
        run_next   = run_reg;
        shreg_next = shreg_reg;
        end_next   = end_reg;
        rd_addr    = w_reg;
        wr_en      = 1'b0;
        wr_addr    = w_reg;
        wr_data    = shift_val;

        unique case (state_reg)
            bpa_pkg::WK_IDLE:
            begin
                if (cmd.go)
                begin
                    op_next    = cmd.op;
                    check_next = cmd.check;
                    stop_next  = 1'b0;
                    w_next     = lo[KW +: AWW];
                    k_next     = '0;
                    run_next   = '0;
                    if (lo >= hi)
                    begin
                        rsp_next.done = 1'b1;
                    end
                    else
                    begin
                        state_next = bpa_pkg::WK_READ;
                    end
                end
            end

            bpa_pkg::WK_READ:
            begin
                state_next = bpa_pkg::WK_LOAD;
            end

            bpa_pkg::WK_LOAD:
            begin
                // fully used word cannot hold a free run
                if (op_reg == bpa_pkg::WALK_SCAN && (&rd_data))
                begin
                    run_next = '0;
                    if (last_word)
                    begin
                        rsp_next.done = 1'b1;
                        state_next    = bpa_pkg::WK_IDLE;
                    end
                    else
                    begin
                        w_next     = w_inc[AWW-1:0];
                        state_next = bpa_pkg::WK_READ;
                    end
                end
                else
                begin
                    shreg_next = rd_data;
                    k_next     = '0;
                    state_next = bpa_pkg::WK_SHIFT;
                end
            end

            bpa_pkg::WK_SHIFT:
            begin
                k_next     = k_reg + KW'(1);
                shreg_next = shift_val;
                case (op_reg) inside
                    bpa_pkg::WALK_SCAN:
                    begin
                        if (active && !bit_cur && run_inc == cnt)
                        begin
                            rsp_next.done  = 1'b1;
                            rsp_next.found = 1'b1;
                            end_next       = q_inc;
                            state_next     = bpa_pkg::WK_IDLE;
                        end
                        else
                        begin
                            if (active)
                            begin
                                run_next = bit_cur ? '0 : run_inc;
                            end
                            if (q_inc == hi)
                            begin
                                rsp_next.done = 1'b1;
                                state_next    = bpa_pkg::WK_IDLE;
                            end
                            else if (k_reg == KMAX)
                            begin
                                w_next     = w_inc[AWW-1:0];
                                state_next = bpa_pkg::WK_READ;
                            end
                        end
                    end

                    bpa_pkg::WALK_PEEK:
                    begin
                        if (q == lo)
                        begin
                            rsp_next.done    = 1'b1;
                            rsp_next.bit_val = bit_cur;
                            state_next       = bpa_pkg::WK_IDLE;
                        end
                    end

                    bpa_pkg::WALK_FILL, bpa_pkg::WALK_CLEAR:
                    begin
                        // checked free stops at the first page already free
                        if (op_reg == bpa_pkg::WALK_CLEAR && check_reg && active && !bit_cur)
                        begin
                            stop_next = 1'b1;
                        end
                        if (k_reg == KMAX)
                        begin
                            wr_en = 1'b1;
                            if (stop_next || last_word)
                            begin
                                rsp_next.done = 1'b1;
                                rsp_next.dbl  = stop_next;
                                state_next    = bpa_pkg::WK_IDLE;
                            end
                            else
                            begin
                                w_next     = w_inc[AWW-1:0];
                                state_next = bpa_pkg::WK_READ;
                            end
                        end
                    end

                    default:
                    begin
                        state_next = bpa_pkg::WK_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = bpa_pkg::WK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpa_pkg::WK_IDLE;
            op_reg    <= bpa_pkg::WALK_SCAN;
            check_reg <= 1'b0;
            stop_reg  <= 1'b0;
            rsp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            check_reg <= check_next;
            stop_reg  <= stop_next;
            rsp_reg   <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg     <= w_next;
        k_reg     <= k_next;
        run_reg   <= run_next;
        shreg_reg <= shreg_next;
        end_reg   <= end_next;
    end

    assign rsp     = rsp_reg;
    assign end_pos = end_reg;

    `ASSERT_CLK(a_go_when_idle, clk, rst_n, cmd.go |-> state_reg == bpa_pkg::WK_IDLE, "walk started while busy")
    `ASSERT_CLK(a_done_pulse, clk, rst_n, rsp_reg.done |=> !rsp_reg.done, "walk done held")

endmodule

FILE: hw/rtl/bitmap_page_allocator_unit.sv
// bitmap page allocator top level: request sequencer, top_page register, result beat register
// after reset the used map is swept to all used, one 64-page word per cycle
// no request beat is taken during the sweep; configuration writes are taken at any time
// check, free, mark: a walk over each 64-page word touched; errors and zero counts skip the walk
// alloc: a scan skips fully used words and shifts through words with a free page, over at most
// two scans, then a walk marks the found run; the next request is taken while a result beat waits
`include "assert_macros.svh"

module bitmap_page_allocator_unit #(
    parameter int PAGES = bpa_pkg::PAGES_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [bpa_pkg::CNT_W-1:0] cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  bpa_pkg::in_item_t         in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output bpa_pkg::out_item_t        out_data
);

    localparam int W     = bpa_pkg::MAP_WORD_W;
    localparam int KW    = bpa_pkg::MAP_BIT_W;
    localparam int CW    = bpa_pkg::CNT_W;
    localparam int PG_W  = bpa_pkg::PAGE_W;
    localparam int DEPTH = (PAGES + W - 1) / W;
    localparam int AWW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = AWW + KW + 1;
    localparam int SW    = ((PW > CW) ? PW : CW) + 1;

    bpa_pkg::ctl_state_t ctl_state_reg, ctl_state_next;
    logic [CW-1:0]       top_reg;
    logic [PW-1:0]       cursor_reg, cursor_next;
    logic [PW-1:0]       old_reg, old_next;
    bpa_pkg::mode_t      mode_reg, mode_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    bpa_pkg::walk_cmd_t  cmd_reg, cmd_next;
    logic [PW-1:0]       lo_reg, lo_next;
    logic [PW-1:0]       hi_reg, hi_next;
    logic [PG_W-1:0]     res_page_reg, res_page_next;
    bpa_pkg::status_t    res_status_reg, res_status_next;
    logic                res_used_reg, res_used_next;
    logic                out_valid_reg, out_valid_next;
    bpa_pkg::out_item_t  out_data_reg, out_data_next;

    bpa_pkg::walk_rsp_t  walk_rsp;
    logic [PW-1:0]       walk_end;
    logic [AWW-1:0]      map_rd_addr;
    logic [W-1:0]        map_rd_data;
    logic                map_wr_en;
    logic [AWW-1:0]      map_wr_addr;
    logic [W-1:0]        map_wr_data;
    logic                map_ready;

    logic [SW-1:0]       pages_c;
    logic [PW-1:0]       top_eff;
    logic [SW-1:0]       range_end;
    logic [PW-1:0]       found_start;
    logic                accept;

    bpa_map #(
        .PAGES (PAGES)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data),
        .ready   (map_ready)
    );

    bpa_walk #(
        .PAGES (PAGES)
    ) u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_reg),
        .lo      (lo_reg),
        .hi      (hi_reg),
        .cnt     (cnt_reg),
        .rsp     (walk_rsp),
        .end_pos (walk_end),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data)
    );

    always_comb
    begin
        pages_c     = SW'(PAGES);
        top_eff     = (SW'(top_reg) > pages_c) ? PW'(PAGES) : PW'(top_reg);
        range_end   = SW'(in_data.page_index) + SW'(in_data.page_count);
        found_start = walk_end - PW'(cnt_reg);
        in_ready    = (ctl_state_reg == bpa_pkg::CTL_IDLE) && map_ready;
        accept      = in_valid && in_ready;
    end

    always_comb
    begin
        ctl_state_next  = ctl_state_reg;
        cursor_next     = cursor_reg;
        old_next        = old_reg;
        mode_next       = mode_reg;
        cnt_next        = cnt_reg;
        cmd_next        = '0;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        res_page_next   = res_page_reg;
        res_status_next = res_status_reg;
        res_used_next   = res_used_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (ctl_state_reg) inside
            bpa_pkg::CTL_IDLE:
            begin
                if (accept)
                begin
                    mode_next       = in_data.mode;
                    cnt_next        = in_data.page_count;
                    res_page_next   = '0;
                    res_status_next = bpa_pkg::ST_OK;
                    res_used_next   = 1'b0;
                    ctl_state_next  = bpa_pkg::CTL_OUT;
                    unique case (in_data.mode) inside
                        bpa_pkg::MODE_ALLOC:
                        begin
                            if (in_data.page_count == '0)
                            begin
                                res_status_next = bpa_pkg::ST_NOSPACE;
                            end
                            else
                            begin
                                old_next       = cursor_reg;
                                lo_next        = cursor_reg;
                                hi_next        = top_eff;
                                cmd_next.go    = 1'b1;
                                cmd_next.op    = bpa_pkg::WALK_SCAN;
                                ctl_state_next = bpa_pkg::CTL_SCAN1;
                            end
                        end

                        bpa_pkg::MODE_CHECK:
                        begin
                            if (SW'(in_data.page_index) >= pages_c)
                            begin
                                res_status_next = bpa_pkg::ST_RANGE;
                            end
                            else
                            begin
                                lo_next        = PW'(in_data.page_index);
                                hi_next        = PW'(in_data.page_index) + PW'(1);
                                cmd_next.go    = 1'b1;
                                cmd_next.op    = bpa_pkg::WALK_PEEK;
                                ctl_state_next = bpa_pkg::CTL_WALK;
                            end
                        end

                        bpa_pkg::MODE_FREE, bpa_pkg::MODE_MARK:
                        begin
                            if (range_end > pages_c)
                            begin
                                res_status_next = bpa_pkg::ST_RANGE;
                            end
                            else if (in_data.page_count != '0)
                            begin
                                lo_next        = PW'(in_data.page_index);
                                hi_next        = PW'(range_end);
                                cmd_next.go    = 1'b1;
                                cmd_next.op    = bpa_pkg::WALK_CLEAR;
                                cmd_next.check = (in_data.mode == bpa_pkg::MODE_FREE);
                                ctl_state_next = bpa_pkg::CTL_WALK;
                            end
                        end

                        default:
                        begin
                            res_status_next = bpa_pkg::ST_RANGE;
                        end
                    endcase
                end
            end

            bpa_pkg::CTL_SCAN1, bpa_pkg::CTL_SCAN2:
            begin
                if (walk_rsp.done)
                begin
                    if (walk_rsp.found)
                    begin
                        cursor_next    = walk_end;
                        res_page_next  = PG_W'(found_start);
                        lo_next        = found_start;
                        hi_next        = walk_end;
                        cmd_next.go    = 1'b1;
                        cmd_next.op    = bpa_pkg::WALK_FILL;
                        ctl_state_next = bpa_pkg::CTL_FILL;
                    end
                    else if (ctl_state_reg == bpa_pkg::CTL_SCAN1)
                    begin
                        // wrap: search from page zero up to the old cursor
                        lo_next        = '0;
                        hi_next        = old_reg;
                        cmd_next.go    = 1'b1;
                        cmd_next.op    = bpa_pkg::WALK_SCAN;
                        ctl_state_next = bpa_pkg::CTL_SCAN2;
                    end
                    else
                    begin
                        res_status_next = bpa_pkg::ST_NOSPACE;
                        ctl_state_next  = bpa_pkg::CTL_OUT;
                    end
                end
            end

            bpa_pkg::CTL_FILL:
            begin
                if (walk_rsp.done)
                begin
                    ctl_state_next = bpa_pkg::CTL_OUT;
                end
            end

            bpa_pkg::CTL_WALK:
            begin
                if (walk_rsp.done)
                begin
                    if (mode_reg == bpa_pkg::MODE_CHECK)
                    begin
                        res_used_next = walk_rsp.bit_val;
                    end
                    if (walk_rsp.dbl)
                    begin
                        res_status_next = bpa_pkg::ST_DOUBLE;
                    end
                    ctl_state_next = bpa_pkg::CTL_OUT;
                end
            end

            bpa_pkg::CTL_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.result_page = res_page_reg;
                    out_data_next.status      = res_status_reg;
                    out_data_next.is_used     = res_used_reg;
                    ctl_state_next            = bpa_pkg::CTL_IDLE;
                end
            end

            default:
            begin
                ctl_state_next = bpa_pkg::CTL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_state_reg <= bpa_pkg::CTL_IDLE;
            top_reg       <= bpa_pkg::TOP_PAGE_RESET;
            cursor_reg    <= '0;
            cmd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ctl_state_reg <= ctl_state_next;
            cursor_reg    <= cursor_next;
            cmd_reg       <= cmd_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                top_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        old_reg        <= old_next;
        mode_reg       <= mode_next;
        cnt_reg        <= cnt_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        res_page_reg   <= res_page_next;
        res_status_reg <= res_status_next;
        res_used_reg   <= res_used_next;
        out_data_reg   <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `ASSERT_CLK(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready |=> ctl_state_reg != bpa_pkg::CTL_IDLE, "request beat lost")
    `ASSERT_CLK(a_found_in_scan, clk, rst_n, walk_rsp.found |-> (ctl_state_reg == bpa_pkg::CTL_SCAN1 || ctl_state_reg == bpa_pkg::CTL_SCAN2), "run found outside scan")
    `ASSERT_CLK(a_out_from_result, clk, rst_n, $rose(out_valid_reg) |-> $past(ctl_state_reg == bpa_pkg::CTL_OUT), "result beat without request")

endmodule

FILE: bench/tb_top.sv
// bitmap page allocator testbench: used-map predictor in a scoreboard, bursty requests, stalled results
package alloc_tb_pkg;
    import bpa_pkg::*;

    localparam int MAP_PAGES = PAGES_DEFAULT;

    class page_map_scoreboard;
        bit        used_map [MAP_PAGES];
        int        cursor;
        int        top_page;
        out_item_t expected_results [$];
        int        live_start [$];
        int        live_count [$];
        int        errors;
        int        tally [4][4];
        int        checks_used;
        int        checks_free;

        function new();
            foreach (used_map[i])
                used_map[i] = 1'b1;
            cursor = 0;
            top_page = TOP_PAGE_RESET;
            errors = 0;
        endfunction

        function void set_top(int value);
            top_page = value;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // next-fit search from the cursor; a found run is marked used
        function bit claim_run(int count, int limit, output int first);
            int run;
            run = 0;
            first = 0;
            if (limit > MAP_PAGES)
                limit = MAP_PAGES;
            while (cursor < limit)
            begin
                cursor++;
                if (used_map[cursor - 1])
                    run = 0;
                else
                begin
                    run++;
                    if (run == count)
                    begin
                        first = cursor - count;
                        for (int i = first; i < cursor; i++)
                            used_map[i] = 1'b1;
                        live_start.push_back(first);
                        live_count.push_back(count);
                        return 1'b1;
                    end
                end
            end
            return 1'b0;
        endfunction

        function bit take_live_run(output int start, output int count);
            int k;
            start = 0;
            count = 0;
            if (live_start.size() == 0)
                return 1'b0;
            k = $urandom_range(0, live_start.size() - 1);
            start = live_start[k];
            count = live_count[k];
            live_start.delete(k);
            live_count.delete(k);
            return 1'b1;
        endfunction

        function out_item_t predict_outcome(in_item_t r);
            out_item_t o;
            int idx, cnt, top, old, first;
            idx = r.page_index;
            cnt = r.page_count;
            o.result_page = '0;
            o.status = ST_OK;
            o.is_used = 1'b0;
            case (r.mode)
                MODE_ALLOC:
                begin
                    top = (top_page > MAP_PAGES) ? MAP_PAGES : top_page;
                    old = cursor;
                    if (cnt == 0)
                        o.status = ST_NOSPACE;
                    else if (claim_run(cnt, top, first))
                        o.result_page = PAGE_W'(first);
                    else
                    begin
                        cursor = 0;
                        if (claim_run(cnt, old, first))
                            o.result_page = PAGE_W'(first);
                        else
                            o.status = ST_NOSPACE;
                    end
                end
                MODE_CHECK:
                begin
                    if (idx >= MAP_PAGES)
                        o.status = ST_RANGE;
                    else
                        o.is_used = used_map[idx];
                end
                default:
                begin
                    if (idx + cnt > MAP_PAGES)
                        o.status = ST_RANGE;
                    else
                    begin
                        for (int i = idx; i < idx + cnt; i++)
                        begin
                            if (r.mode == MODE_FREE && !used_map[i])
                            begin
                                o.status = ST_DOUBLE;
                                break;
                            end
                            used_map[i] = 1'b0;
                        end
                    end
                end
            endcase
            return o;
        endfunction

        function void note_request(in_item_t r);
            out_item_t want;
            want = predict_outcome(r);
            expected_results.push_back(want);
            tally[int'(r.mode)][int'(want.status)]++;
            if (r.mode == MODE_CHECK && want.status == ST_OK)
            begin
                if (want.is_used)
                    checks_used++;
                else
                    checks_free++;
            end
        endfunction

        function void check_result(out_item_t got, realtime now);
            out_item_t want;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("@%0.1f ns: unexpected result beat, page %0d status %0d used %0b",
                         now, got.result_page, got.status, got.is_used);
                return;
            end
            want = expected_results.pop_front();
            if (got.result_page !== want.result_page)
            begin
                errors++;
                $display("@%0.1f ns: result_page expected %0d actual %0d",
                         now, want.result_page, got.result_page);
            end
            if (got.status !== want.status)
            begin
                errors++;
                $display("@%0.1f ns: status expected %0d actual %0d",
                         now, want.status, got.status);
            end
            if (got.is_used !== want.is_used)
            begin
                errors++;
                $display("@%0.1f ns: is_used expected %0b actual %0b",
                         now, want.is_used, got.is_used);
            end
        endfunction

        function void report_summary();
            $display("covered: alloc %0d ok / %0d no space, free %0d ok / %0d double / %0d range",
                     tally[MODE_ALLOC][ST_OK], tally[MODE_ALLOC][ST_NOSPACE],
                     tally[MODE_FREE][ST_OK], tally[MODE_FREE][ST_DOUBLE],
                     tally[MODE_FREE][ST_RANGE]);
            $display("covered: check %0d used / %0d free, mark %0d ok / %0d range, %0d errors",
                     checks_used, checks_free, tally[MODE_MARK][ST_OK],
                     tally[MODE_MARK][ST_RANGE], errors);
        endfunction
    endclass
endpackage

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bpa_pkg::*;
    import alloc_tb_pkg::*;

    localparam int N_RANDOM      = 1800;
    localparam int N_PHASES      = 8;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 200;
    localparam int HOLD_CYCLES   = 600;
    // room for the worst request (two full scans plus marking) plus stalls, many times over
    localparam int LIMIT_CYCLES  = 100_000_000;

    typedef enum {SINK_OPEN, SINK_PATTERN, SINK_LIGHT, SINK_HEAVY} sink_style_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;
    logic             in_valid;
    logic             in_ready;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_ready;
    out_item_t        out_data;

    page_map_scoreboard sb;
    int cycle_count  = 0;
    int results_seen = 0;

    bitmap_page_allocator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic in_item_t make_req(mode_t m, int idx, int cnt);
        in_item_t r;
        r.mode = m;
        r.page_index = PAGE_W'(idx);
        r.page_count = CNT_W'(cnt);
        return r;
    endfunction

    function automatic int pick_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return 0;
        if (roll < 75)
            return $urandom_range(1, 16);
        if (roll < 95)
            return $urandom_range(17, 200);
        return $urandom_range(201, 8191);
    endfunction

    task automatic send_request(in_item_t r);
        @(negedge clk);
        in_valid = 1'b1;
        in_data = r;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(r);
    endtask

    task automatic sender_idle(int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
    endtask

    task automatic drain_results();
        sender_idle(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_top_page(int value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = CNT_W'(value);
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_top(value);
    endtask

    initial
    begin : result_sink
        sink_style_t style;
        int          style_left;
        bit [15:0]   stall_bits;
        bit          held;
        out_ready = 1'b0;
        style = SINK_OPEN;
        style_left = 0;
        stall_bits = '0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid && out_ready)
            begin
                sb.check_result(out_data, $realtime);
                results_seen++;
            end
            @(negedge clk);
            if (rst_n !== 1'b1)
                continue;
            // long hold-off while requests keep coming, so the input side backs up
            if (!held && results_seen >= 300 && in_valid)
            begin
                held = 1'b1;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (style_left == 0)
            begin
                style_left = $urandom_range(30, 300);
                style = sink_style_t'($urandom_range(0, 3));
                stall_bits = 16'($urandom) | 16'h1;
            end
            style_left--;
            case (style)
                SINK_OPEN:
                    out_ready = 1'b1;
                SINK_PATTERN:
                begin
                    out_ready = stall_bits[0];
                    stall_bits = {stall_bits[0], stall_bits[15:1]};
                end
                SINK_LIGHT:
                    out_ready = ($urandom_range(0, 3) != 0);
                default:
                    out_ready = ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    initial
    begin : stimulus
        in_item_t req;
        int       phase_tops [N_PHASES];
        int       roll, idx, region, s, c, burst, sent;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        in_data = '0;
        sb = new();
        phase_tops = '{8191, 512, 0, 4095, 1, 1024, 0, 4096};
        phase_tops[6] = $urandom_range(2, 4096);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        write_top_page(TOP_PAGE_RESET);

        // map starts fully used
        send_request(make_req(MODE_ALLOC, 0, 0));
        send_request(make_req(MODE_ALLOC, 4095, 1));
        send_request(make_req(MODE_CHECK, 0, 0));
        send_request(make_req(MODE_CHECK, 4095, 8191));
        send_request(make_req(MODE_MARK, 0, 0));
        send_request(make_req(MODE_MARK, 4095, 2));
        send_request(make_req(MODE_MARK, 0, 8191));
        send_request(make_req(MODE_FREE, 100, 0));
        send_request(make_req(MODE_MARK, 0, 4096));
        send_request(make_req(MODE_CHECK, 4095, 0));
        send_request(make_req(MODE_FREE, 10, 5));
        send_request(make_req(MODE_ALLOC, 0, 4096));
        send_request(make_req(MODE_ALLOC, 0, 1));
        send_request(make_req(MODE_FREE, 4000, 96));
        send_request(make_req(MODE_FREE, 4000, 1));
        send_request(make_req(MODE_ALLOC, 0, 97));
        send_request(make_req(MODE_ALLOC, 0, 96));
        send_request(make_req(MODE_MARK, 0, 64));
        send_request(make_req(MODE_ALLOC, 0, 32));
        // partial free that stops at the first page already free
        send_request(make_req(MODE_FREE, 30, 4));
        send_request(make_req(MODE_ALLOC, 0, 8191));
        send_request(make_req(MODE_CHECK, 31, 0));
        send_request(make_req(MODE_FREE, 4095, 1));
        send_request(make_req(MODE_MARK, 4095, 1));
        send_request(make_req(MODE_ALLOC, 0, 2));

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            drain_results();
            write_top_page(phase_tops[ph]);
            sent = 0;
            while (sent < N_RANDOM / N_PHASES)
            begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
                repeat (burst)
                begin
                    roll = $urandom_range(0, 99);
                    region = (sb.top_page > MAP_PAGES) ? MAP_PAGES : sb.top_page;
                    if (sb.cursor > region)
                        region = sb.cursor;
                    if (region < 256)
                        region = 256;
                    idx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, region - 1)
                                                     : $urandom_range(0, MAP_PAGES - 1);
                    if (roll < 35)
                        req = make_req(MODE_ALLOC, $urandom_range(0, MAP_PAGES - 1),
                                       pick_count());
                    else if (roll < 60 && sb.take_live_run(s, c))
                        req = make_req(MODE_FREE, s, c);
                    else if (roll < 70)
                        req = make_req(MODE_FREE, idx, pick_count());
                    else if (roll < 85)
                        req = make_req(MODE_CHECK, idx, $urandom_range(0, 8191));
                    else
                        req = make_req(MODE_MARK, idx, pick_count());
                    send_request(req);
                    sent++;
                end
                if ($urandom_range(0, 3) != 0)
                    sender_idle($urandom_range(1, 30));
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.report_summary();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
        begin
            $display("%0d errors, %0d results never arrived", sb.errors, sb.pending());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
